### sv/teleg_pkg.sv
// ----------------------------------------------------------------------------
// teleg_pkg
// Shared types and constants for the telemetry ack ring and emit gate.
// ----------------------------------------------------------------------------
package teleg_pkg;

  localparam int RING_DEPTH = 8;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // input opcodes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_POLL   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEATS   = 2'd3;

  // emit modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_ALWAYS = 2'd2;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [27:0] corr_id;
    logic [3:0]  err_code;
    logic [31:0] time_ms;
    logic        move_active;
    logic        wheels_moving;
    logic        force_req;
  } teleg_in_t;

  typedef struct packed {
    logic        item_kind;
    logic        frame_sent;
    logic [6:0]  seq_number;
    logic [3:0]  ack_count;
    logic [31:0] ack_word;
    logic        last;
  } teleg_out_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_PUSH,
    RING_ROT
  } teleg_ring_op_e;

  typedef struct packed {
    teleg_ring_op_e op;
    logic [31:0]    word;
  } teleg_ring_cmd_t;

  typedef struct packed {
    logic [31:0]       head_word;
    logic [FILL_W-1:0] fill;
    logic              pending;
  } teleg_ring_sts_t;

  typedef struct packed {
    logic en;
    logic bump;
  } teleg_cell_ctl_t;

endpackage

### sv/telemetry_ack_ring_emit_gate_unit.sv
// ----------------------------------------------------------------------------
// telemetry_ack_ring_emit_gate_unit
// Ack ring with telemetry emit gate: push, control-cycle update, emit poll.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// command   in         start_i / busy_o             cmd_i  (teleg_in_t)
// result    out        result_valid_o (strobe)      result_o (teleg_out_t)
// config    in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// Push and update give no result. A poll gives its header in the cycle after
// the transfer; an emitted frame with N queued acks, N up to RING_DEPTH, then
// gives one entry per cycle, staying busy while the cell chain rotates once
// around the filled part. Reset clears the control state and loads the config
// defaults; the receiver cannot stall the results.
// ----------------------------------------------------------------------------
module telemetry_ack_ring_emit_gate_unit import teleg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  teleg_in_t             cmd_i,
  output logic                  result_valid_o,
  output teleg_out_t            result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [FILL_W-1:0] left_q;
  logic [6:0]        seq_q;
  logic [6:0]        frame_seq_q;
  logic              emitted_q;
  logic [31:0]       last_emit_q;
  logic              moved_q;
  logic [31:0]       last_act_q;
  logic              active_q;
  logic              valid_q;
  logic              valid_d;
  teleg_out_t        res_q;
  teleg_out_t        res_d;

  logic [1:0]  mode_q;
  logic [15:0] period_q;
  logic [15:0] holdoff_q;
  logic [3:0]  repeats_q;

  teleg_ring_cmd_t ring_cmd;
  teleg_ring_sts_t ring_sts;

  logic        take;
  logic [31:0] act_dt;
  logic [31:0] emit_dt;
  logic        in_holdoff;
  logic        activity;
  logic        unsol;
  logic        due;
  logic        go;

  assign take        = start_i && (state_q == ST_IDLE);
  assign busy_o      = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  assign act_dt     = cmd_i.time_ms - last_act_q;
  assign emit_dt    = cmd_i.time_ms - last_emit_q;
  assign in_holdoff = moved_q && (act_dt < {16'd0, holdoff_q});
  assign activity   = active_q || in_holdoff;
  assign unsol      = (mode_q == MODE_AUTO) ? activity : (mode_q == MODE_ALWAYS);
  assign due        = !emitted_q || (emit_dt >= {16'd0, period_q});
  assign go         = due && (cmd_i.force_req || unsol || ring_sts.pending);

  always_comb begin
    ring_cmd.op   = RING_HOLD;
    ring_cmd.word = {cmd_i.corr_id, cmd_i.err_code};
    if (state_q == ST_EMIT) begin
      ring_cmd.op = RING_ROT;
    end else if (take && (cmd_i.opcode == OP_PUSH)) begin
      ring_cmd.op = RING_PUSH;
    end
  end

  teleg_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ring_cmd),
    .repeats_i (repeats_q),
    .sts_o     (ring_sts)
  );

  // result strobe and payload for the next cycle
  always_comb begin
    valid_d = 1'b0;
    res_d   = res_q;
    if (state_q == ST_EMIT) begin
      valid_d          = 1'b1;
      res_d            = '0;
      res_d.item_kind  = KIND_ENTRY;
      res_d.seq_number = seq_q;
      res_d.ack_word   = ring_sts.head_word;
      res_d.last       = left_q == FILL_W'(1);
    end else if (take && (cmd_i.opcode == OP_POLL)) begin
      valid_d = 1'b1;
      res_d   = '0;
      if (go) begin
        res_d.frame_sent = 1'b1;
        res_d.seq_number = frame_seq_q;
        res_d.ack_count  = 4'(ring_sts.fill);
        res_d.last       = ring_sts.fill == '0;
      end else begin
        res_d.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_AUTO;
      period_q  <= 16'd50;
      holdoff_q <= 16'd500;
      repeats_q <= 4'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EMIT_MODE: mode_q    <= cfg_data_i[1:0];
        CFG_PERIOD:    period_q  <= cfg_data_i;
        CFG_HOLDOFF:   holdoff_q <= cfg_data_i;
        CFG_REPEATS:   repeats_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= '0;
      seq_q       <= '0;
      frame_seq_q <= '0;
      emitted_q   <= 1'b0;
      last_emit_q <= '0;
      moved_q     <= 1'b0;
      last_act_q  <= '0;
      active_q    <= 1'b0;
      valid_q     <= 1'b0;
      res_q       <= '0;
    end else begin
      valid_q <= valid_d;
      res_q   <= res_d;
      unique case (state_q)
        ST_IDLE: begin
          if (take && (cmd_i.opcode == OP_UPDATE)) begin
            active_q <= cmd_i.move_active;
            if (cmd_i.move_active) begin
              moved_q    <= 1'b1;
              last_act_q <= cmd_i.time_ms;
            end else if (in_holdoff && cmd_i.wheels_moving) begin
              last_act_q <= cmd_i.time_ms;
            end
          end
          if (take && (cmd_i.opcode == OP_POLL) && go) begin
            seq_q       <= frame_seq_q;
            frame_seq_q <= frame_seq_q + 7'd1;
            emitted_q   <= 1'b1;
            last_emit_q <= cmd_i.time_ms;
            left_q      <= ring_sts.fill;
            if (ring_sts.fill != '0) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          left_q <= left_q - FILL_W'(1);
          if (left_q == FILL_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

### sv/teleg_cell.sv
// ----------------------------------------------------------------------------
// teleg_cell
// One ring slot: ack word plus send counter, loaded from its neighbor or with a pushed word.
// ----------------------------------------------------------------------------
module teleg_cell import teleg_pkg::*; (
  input  logic            clk_i,
  input  teleg_cell_ctl_t ctl_i,
  input  logic [31:0]     word_i,
  input  logic [3:0]      cnt_i,
  input  logic [3:0]      repeats_i,
  output logic [31:0]     word_o,
  output logic [3:0]      cnt_o,
  output logic            below_o
);

  logic [31:0] word_q;
  logic [3:0]  cnt_q;
  logic [3:0]  cnt_d;

  // counter saturates at the repeat count
  always_comb begin
    cnt_d = cnt_i;
    if (ctl_i.bump && (cnt_i < repeats_i)) begin
      cnt_d = cnt_i + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      word_q <= word_i;
      cnt_q  <= cnt_d;
    end
  end

  assign word_o  = word_q;
  assign cnt_o   = cnt_q;
  assign below_o = cnt_q < repeats_i;

endmodule

### sv/teleg_ring.sv
// ----------------------------------------------------------------------------
// teleg_ring
// Chain of ack cells, oldest entry in cell 0. Push appends or shifts out the
// oldest; rotate sends cell 0 to the tail of the filled part with a bump.
// ----------------------------------------------------------------------------
module teleg_ring import teleg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  teleg_ring_cmd_t cmd_i,
  input  logic [3:0]      repeats_i,
  output teleg_ring_sts_t sts_o
);

  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_d;
  logic [FILL_W-1:0] fill_last;
  logic              full;

  logic [31:0]     word_s  [RING_DEPTH];
  logic [3:0]      cnt_s   [RING_DEPTH];
  logic            below_s [RING_DEPTH];
  logic [31:0]     word_in [RING_DEPTH];
  logic [3:0]      cnt_in  [RING_DEPTH];
  teleg_cell_ctl_t ctl     [RING_DEPTH];

  assign full      = fill_q == FILL_W'(RING_DEPTH);
  assign fill_last = fill_q - FILL_W'(1);

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    localparam logic [FILL_W-1:0] IDX = FILL_W'(i);
    localparam int NXT = (i + 1) % RING_DEPTH;

    always_comb begin
      ctl[i]     = '0;
      word_in[i] = word_s[NXT];
      cnt_in[i]  = cnt_s[NXT];
      unique case (cmd_i.op)
        RING_PUSH: begin
          if (full) begin
            ctl[i].en = 1'b1;
            if (i == RING_DEPTH - 1) begin
              word_in[i] = cmd_i.word;
              cnt_in[i]  = 4'd0;
            end
          end else begin
            ctl[i].en  = fill_q == IDX;
            word_in[i] = cmd_i.word;
            cnt_in[i]  = 4'd0;
          end
        end
        RING_ROT: begin
          // cell 0 wraps around to the tail cell of the filled part
          ctl[i].en   = IDX < fill_q;
          ctl[i].bump = IDX == fill_last;
          if (IDX == fill_last) begin
            word_in[i] = word_s[0];
            cnt_in[i]  = cnt_s[0];
          end
        end
        default: ;
      endcase
    end

    teleg_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl[i]),
      .word_i    (word_in[i]),
      .cnt_i     (cnt_in[i]),
      .repeats_i (repeats_i),
      .word_o    (word_s[i]),
      .cnt_o     (cnt_s[i]),
      .below_o   (below_s[i])
    );
  end

  always_comb begin
    sts_o.pending = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if ((FILL_W'(i) < fill_q) && below_s[i]) begin
        sts_o.pending = 1'b1;
      end
    end
  end

  assign sts_o.head_word = word_s[0];
  assign sts_o.fill      = fill_q;

  always_comb begin
    fill_d = fill_q;
    if ((cmd_i.op == RING_PUSH) && !full) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

### sv/teleg_chk.sv
// ----------------------------------------------------------------------------
// teleg_chk
// Port-level checks on the command and result sequencing.
// ----------------------------------------------------------------------------
module teleg_chk import teleg_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input teleg_in_t  cmd_i,
  input logic       result_valid_o,
  input teleg_out_t result_o
);

  // push and update transfers produce nothing
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i.opcode != OP_POLL)) |=> !result_valid_o)
    else $error("result after a non-poll transfer");

  a_header_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i.opcode == OP_POLL)) |=>
      (result_valid_o && (result_o.item_kind == KIND_HEADER)))
    else $error("poll without header in next cycle");

  a_idle_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.item_kind == KIND_HEADER) && !result_o.frame_sent) |->
      (result_o.last && (result_o.seq_number == 7'd0) && (result_o.ack_count == 4'd0)))
    else $error("malformed no-frame header");

  a_entries_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |=>
      (result_valid_o && (result_o.item_kind == KIND_ENTRY)))
    else $error("gap in frame entries");

  a_busy_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy_o)
    else $error("not busy while frame entries remain");

endmodule

bind telemetry_ack_ring_emit_gate_unit teleg_chk u_teleg_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
